/* src/hrb_pkg.sv */
// Package with shared constants, types and codes of the hypercube router buffer.
package hrb_pkg;
  localparam int unsigned BufDepth    = 7;
  localparam int unsigned ProcBits    = 4;
  localparam int unsigned DimCount    = 12;
  localparam int unsigned PayloadBits = 32;

  localparam logic [1:0] OP_RECEIVE = 2'd0;
  localparam logic [1:0] OP_FORWARD = 2'd1;
  localparam logic [1:0] OP_INJECT  = 2'd2;
  localparam logic [1:0] OP_DELIVER = 2'd3;

  localparam logic [2:0] KIND_FORWARDED = 3'd0;
  localparam logic [2:0] KIND_REFERRED  = 3'd1;
  localparam logic [2:0] KIND_DELIVERED = 3'd2;
  localparam logic [2:0] KIND_ACCEPTED  = 3'd3;
  localparam logic [2:0] KIND_REJECTED  = 3'd4;

  typedef struct packed {
    logic [1:0]  op;
    logic [3:0]  dimension;
    logic [3:0]  processor;
    logic [15:0] address;
    logic [31:0] payload;
    logic        parity;
    logic        separator;
    logic        or_mode;
  } in_word_t;

  typedef struct packed {
    logic [2:0]  kind;
    logic [3:0]  port;
    logic [3:0]  processor_res;
    logic [15:0] address_res;
    logic [31:0] payload_res;
    logic        parity_res;
    logic        last;
  } out_word_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_EMIT,
    ST_COMPACT
  } exec_state_t;
endpackage

/* src/hrb_if.sv */
// Valid/ready channel interface used for the input and result words.
interface hrb_in_if import hrb_pkg::*; ();
  logic     valid;
  logic     ready;
  in_word_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface hrb_out_if import hrb_pkg::*; ();
  logic      valid;
  logic      ready;
  out_word_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

/* src/hrb_front.sv */
// Front end: accepts input words, masks fields and queues them in a short FIFO.
module hrb_front import hrb_pkg::*; #(
  parameter int unsigned PROC_BITS    = ProcBits,
  parameter int unsigned DIM_COUNT    = DimCount,
  parameter int unsigned PAYLOAD_BITS = PayloadBits
) (
  input  logic     clk,
  input  logic     rst_n,
  hrb_in_if.sink   in_ch,
  output logic     q_valid,
  output in_word_t q_data,
  input  logic     q_pop
);
  localparam int unsigned AddrBits = DIM_COUNT + PROC_BITS;

  in_word_t  fifo_r [2];
  logic      wptr_r, rptr_r;
  logic [1:0] cnt_r;
  in_word_t  masked;
  logic      push;

  always_comb begin
    masked = in_ch.data;
    for (int i = 0; i < 16; i++) begin
      if (i >= AddrBits) begin
        masked.address[i] = 1'b0;
      end
    end
    for (int i = 0; i < 32; i++) begin
      if (i >= PAYLOAD_BITS) begin
        masked.payload[i] = 1'b0;
      end
    end
  end

  assign in_ch.ready = (cnt_r != 2'd2);
  assign push        = in_ch.valid && in_ch.ready;
  assign q_valid     = (cnt_r != 2'd0);
  assign q_data      = fifo_r[rptr_r];

  always_ff @(posedge clk) begin
    if (push) begin
      fifo_r[wptr_r] <= masked;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r <= 1'b0;
      rptr_r <= 1'b0;
      cnt_r  <= 2'd0;
    end else begin
      if (push) begin
        wptr_r <= ~wptr_r;
      end
      if (q_pop) begin
        rptr_r <= ~rptr_r;
      end
      cnt_r <= cnt_r + {1'b0, push} - {1'b0, q_pop};
    end
  end
endmodule

/* src/hrb_back.sv */
// Back end: executes one queued word on the message store and emits result words.
module hrb_back import hrb_pkg::*; #(
  parameter int unsigned BUF_DEPTH    = BufDepth,
  parameter int unsigned PROC_BITS    = ProcBits,
  parameter int unsigned DIM_COUNT    = DimCount
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic [11:0] router_id,
  input  logic        q_valid,
  input  in_word_t    q_data,
  output logic        q_pop,
  hrb_out_if.source   out_ch
);
  localparam int unsigned ProcCount = 1 << PROC_BITS;
  localparam int unsigned PW        = PROC_BITS + 1;
  localparam int unsigned IW        = (BUF_DEPTH > 1) ? $clog2(BUF_DEPTH) : 1;
  localparam int unsigned NW        = $clog2(BUF_DEPTH + 1);

  logic [15:0] addr_r [BUF_DEPTH];
  logic [31:0] pay_r  [BUF_DEPTH];
  logic        par_r  [BUF_DEPTH];
  logic [BUF_DEPTH-1:0] valid_r, valid_nxt;

  exec_state_t state_r, state_nxt;
  in_word_t    cur_r;
  logic [PW-1:0] proc_r, proc_nxt;
  out_word_t   pend_r, pend_nxt;
  logic        pend_valid_r, pend_valid_nxt;
  out_word_t   obuf_r;
  logic        obuf_valid_r;

  logic [NW-1:0] used;
  logic          full;
  logic [4:0]    pos;
  logic          fwd_hit;
  logic [IW-1:0] fwd_idx;
  logic          dlv_found;
  logic [31:0]   dlv_acc;
  logic [BUF_DEPTH-1:0] dlv_clear;
  logic          pay_par;
  logic          in_ok;
  logic          obuf_free;
  logic          store_wr;
  logic          do_compact;
  logic          gap;
  logic [IW-1:0] hole_idx;

  assign obuf_free = !obuf_valid_r || out_ch.ready;
  assign out_ch.valid = obuf_valid_r;
  assign out_ch.data  = obuf_r;

  always_comb begin
    used = '0;
    for (int i = 0; i < BUF_DEPTH; i++) begin
      used = used + NW'(valid_r[i]);
    end
  end
  assign full = (used == NW'(BUF_DEPTH));
  assign pos  = 5'(DIM_COUNT - 1 + PROC_BITS) - 5'(cur_r.dimension);
  assign pay_par = ^cur_r.payload;
  assign in_ok = !full && cur_r.separator && (cur_r.parity == pay_par);

  always_comb begin
    fwd_hit = 1'b0;
    fwd_idx = '0;
    for (int i = BUF_DEPTH - 1; i >= 0; i--) begin
      if (valid_r[i] && addr_r[i][pos[3:0]]) begin
        fwd_hit = 1'b1;
        fwd_idx = IW'(i);
      end
    end
  end

  always_comb begin
    dlv_found = 1'b0;
    dlv_acc   = '0;
    dlv_clear = '0;
    for (int i = 0; i < BUF_DEPTH; i++) begin
      if (valid_r[i] && (addr_r[i] >> PROC_BITS) == 16'd0
          && addr_r[i][PROC_BITS-1:0] == proc_r[PROC_BITS-1:0]) begin
        if (cur_r.or_mode) begin
          dlv_acc = dlv_acc | pay_r[i];
          dlv_found = 1'b1;
          dlv_clear[i] = 1'b1;
        end else if (!dlv_found) begin
          dlv_acc = pay_r[i];
          dlv_found = 1'b1;
          dlv_clear[i] = 1'b1;
        end
      end
    end
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (q_valid) begin
          state_nxt = ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (cur_r.op == OP_DELIVER) begin
          if (proc_r == PW'(ProcCount - 1) || !obuf_free) begin
            state_nxt = (proc_r == PW'(ProcCount - 1) && obuf_free) ? ST_EMIT : ST_SCAN;
          end
        end else begin
          state_nxt = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (!pend_valid_r || obuf_free) begin
          state_nxt = ST_COMPACT;
        end
      end
      ST_COMPACT: state_nxt = ST_IDLE;
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    q_pop          = 1'b0;
    valid_nxt      = valid_r;
    proc_nxt       = proc_r;
    pend_nxt       = pend_r;
    pend_valid_nxt = pend_valid_r;
    store_wr       = 1'b0;
    do_compact     = 1'b0;
    case (state_r)
      ST_IDLE: begin
        q_pop = q_valid;
        proc_nxt = '0;
        pend_valid_nxt = 1'b0;
      end
      ST_SCAN: begin
        pend_nxt = '0;
        case (cur_r.op)
          OP_RECEIVE: begin
            if (full) begin
              pend_nxt.kind = KIND_REFERRED;
              pend_nxt.address_res = cur_r.address ^ 16'({4'd0, router_id} << PROC_BITS);
              if (DIM_COUNT + PROC_BITS < 16) begin
                pend_nxt.address_res = pend_nxt.address_res
                  & 16'((17'd1 << (DIM_COUNT + PROC_BITS)) - 17'd1);
              end
              pend_nxt.payload_res = cur_r.payload;
              pend_nxt.parity_res = cur_r.parity;
              pend_nxt.last = 1'b1;
              pend_valid_nxt = 1'b1;
            end else begin
              store_wr = 1'b1;
            end
          end
          OP_FORWARD: begin
            if (cur_r.dimension < 4'(DIM_COUNT) && fwd_hit) begin
              pend_nxt.kind = KIND_FORWARDED;
              pend_nxt.port = cur_r.dimension;
              pend_nxt.address_res = addr_r[fwd_idx];
              pend_nxt.address_res[pos[3:0]] = 1'b0;
              pend_nxt.payload_res = pay_r[fwd_idx];
              pend_nxt.parity_res = par_r[fwd_idx];
              pend_nxt.last = 1'b1;
              pend_valid_nxt = 1'b1;
              valid_nxt[fwd_idx] = 1'b0;
            end
          end
          OP_INJECT: begin
            pend_nxt.kind = in_ok ? KIND_ACCEPTED : KIND_REJECTED;
            pend_nxt.processor_res = cur_r.processor;
            pend_nxt.last = 1'b1;
            pend_valid_nxt = 1'b1;
            store_wr = in_ok;
          end
          default: begin
            pend_nxt = pend_r;
            if (obuf_free) begin
              if (dlv_found) begin
                valid_nxt = valid_r & ~dlv_clear;
                pend_nxt = '0;
                pend_nxt.kind = KIND_DELIVERED;
                pend_nxt.processor_res = 4'(proc_r);
                pend_nxt.address_res = 16'(proc_r[PROC_BITS-1:0]);
                pend_nxt.payload_res = dlv_acc;
                pend_valid_nxt = 1'b1;
              end
              proc_nxt = proc_r + PW'(1);
            end
          end
        endcase
      end
      ST_EMIT: begin
        if (!pend_valid_r || obuf_free) begin
          pend_valid_nxt = 1'b0;
        end
      end
      ST_COMPACT: do_compact = 1'b1;
      default: ;
    endcase
  end

  // The previous delivered word goes out when a newer one replaces it.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      obuf_valid_r <= 1'b0;
    end else if (state_r == ST_SCAN && cur_r.op == OP_DELIVER && obuf_free
                 && dlv_found && pend_valid_r) begin
      obuf_valid_r <= 1'b1;
      obuf_r <= pend_r;
    end else if (state_r == ST_EMIT && pend_valid_r && obuf_free) begin
      obuf_valid_r <= 1'b1;
      obuf_r <= pend_r;
      obuf_r.last <= 1'b1;
    end else if (out_ch.ready) begin
      obuf_valid_r <= 1'b0;
    end
  end

  // Compaction closes one gap per cycle; the state stays until the prefix is dense.
  always_comb begin
    gap = 1'b0;
    for (int i = 0; i < BUF_DEPTH - 1; i++) begin
      if (!valid_r[i] && valid_r[i+1]) begin
        gap = 1'b1;
      end
    end
  end

  always_comb begin
    hole_idx = '0;
    for (int i = BUF_DEPTH - 2; i >= 0; i--) begin
      if (!valid_r[i]) begin
        hole_idx = IW'(i);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == ST_IDLE && q_valid) begin
      cur_r <= q_data;
    end
    pend_r <= pend_nxt;
    if (store_wr) begin
      addr_r[used[IW-1:0]] <= cur_r.address;
      pay_r[used[IW-1:0]]  <= cur_r.payload;
      par_r[used[IW-1:0]]  <= cur_r.parity;
    end
    if (do_compact && gap) begin
      for (int j = 0; j < BUF_DEPTH - 1; j++) begin
        if (IW'(j) >= hole_idx) begin
          addr_r[j] <= addr_r[j+1];
          pay_r[j]  <= pay_r[j+1];
          par_r[j]  <= par_r[j+1];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      valid_r      <= '0;
      proc_r       <= '0;
      pend_valid_r <= 1'b0;
    end else begin
      state_r      <= (do_compact && gap) ? ST_COMPACT : state_nxt;
      proc_r       <= proc_nxt;
      pend_valid_r <= pend_valid_nxt;
      if (store_wr) begin
        valid_r[used[IW-1:0]] <= 1'b1;
      end else if (do_compact) begin
        if (gap) begin
          for (int j = 0; j < BUF_DEPTH - 1; j++) begin
            if (IW'(j) >= hole_idx) begin
              valid_r[j] <= valid_r[j+1];
            end
          end
          valid_r[BUF_DEPTH-1] <= 1'b0;
        end
      end else begin
        valid_r <= valid_nxt;
      end
    end
  end
endmodule

/* src/hypercube_router_buffer.sv */
// Top level of the hypercube router buffer.
// The in channel takes one operation word: receive, forward, inject or deliver.
// The out channel gives zero or more result words for it; last marks the final
// one. cfg_we with cfg_wdata loads router_id, which is zero after reset.
// A word passes the front FIFO (two entries), then the executor reads and
// updates the message store, one word at a time. The executor takes the word,
// scans it, hands the result to the output register and then compacts the
// store. Deliver scans every processor number, one per cycle while the output
// register is free. Compaction repeats while kept messages must move down.
// Synchronous reset empties the buffer, the front FIFO and the output register.
// When the receiver stalls, results wait in the output register and the
// executor holds; the FIFO keeps taking words until it is full.
module hypercube_router_buffer import hrb_pkg::*; #(
  parameter int unsigned BUF_DEPTH    = BufDepth,
  parameter int unsigned PROC_BITS    = ProcBits,
  parameter int unsigned DIM_COUNT    = DimCount,
  parameter int unsigned PAYLOAD_BITS = PayloadBits
) (
  input  logic        clk,
  input  logic        rst_n,
  hrb_in_if.sink      in_ch,
  hrb_out_if.source   out_ch,
  input  logic        cfg_we,
  input  logic [11:0] cfg_wdata
);
  logic [11:0] router_id_r;
  logic        q_valid, q_pop;
  in_word_t    q_data;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      router_id_r <= '0;
    end else if (cfg_we) begin
      router_id_r <= cfg_wdata;
    end
  end

  hrb_front #(
    .PROC_BITS(PROC_BITS), .DIM_COUNT(DIM_COUNT), .PAYLOAD_BITS(PAYLOAD_BITS)
  ) u_front (
    .clk, .rst_n, .in_ch, .q_valid, .q_data, .q_pop
  );

  hrb_back #(
    .BUF_DEPTH(BUF_DEPTH), .PROC_BITS(PROC_BITS), .DIM_COUNT(DIM_COUNT)
  ) u_back (
    .clk, .rst_n, .router_id(router_id_r), .q_valid, .q_data, .q_pop, .out_ch
  );
endmodule
